// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the gyro frame parser.
// Depends on nothing; the including module supplies clk and rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off during reset.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, sampled on clk, off during reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPLIES(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/core/gfp_pkg.sv =====
// Constants, types and register map of the gyro frame parser.
// Used by the channel interfaces and the top level.
package gfp_pkg;

  localparam logic [7:0] HDR_FIRST  = 8'hAA;
  localparam logic [7:0] HDR_SECOND = 8'h00;

  localparam int FRAME_LEN = 13;
  localparam int SUM_LEN   = 11;
  localparam int IDX_W     = $clog2(FRAME_LEN);

  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(FRAME_LEN - 1);
  localparam logic [IDX_W-1:0] SUM_LIMIT = IDX_W'(SUM_LEN);

  localparam int BYTE_W  = 8;
  localparam int VALUE_W = 16;
  localparam int UNW_W   = 32;

  // Register map: one 16-bit register per 32-bit word.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_WRAP_THRESHOLD = 1'b0;
  localparam logic REG_TURN_SPAN      = 1'b1;

  localparam logic [VALUE_W-1:0] WRAP_THRESHOLD_RST = 16'd18000;
  localparam logic [VALUE_W-1:0] TURN_SPAN_RST      = 16'd36000;

  localparam logic signed [VALUE_W-1:0] TURN_MAX = 16'sh7FFF;
  localparam logic signed [VALUE_W-1:0] TURN_MIN = 16'sh8000;

  localparam logic [UNW_W-1:0] UNW_MAX = 32'h7FFF_FFFF;
  localparam logic [UNW_W-1:0] UNW_MIN = 32'h8000_0000;

  typedef enum logic [2:0] {
    ST_SYNC = 3'b001,
    ST_ZERO = 3'b010,
    ST_LOAD = 3'b100
  } hunt_t;

  typedef logic signed [VALUE_W-1:0] value_t;

endpackage

// ===== rtl/core/gfp_ifs.sv =====
// Valid/ready channel interfaces of the gyro frame parser:
// received bytes in, parsed frame results out. Uses gfp_pkg.
interface gfp_in_if;
  import gfp_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface gfp_out_if;
  import gfp_pkg::*;
  logic             valid;
  logic             ready;
  logic             checksum_ok;
  value_t           angle_raw;
  value_t           accel_x;
  value_t           accel_y;
  value_t           accel_z;
  value_t           turns;
  logic signed [UNW_W-1:0] unwrapped_angle;

  modport source (
    output valid, output checksum_ok, output angle_raw, output accel_x,
    output accel_y, output accel_z, output turns, output unwrapped_angle,
    input ready
  );
  modport sink (
    input valid, input checksum_ok, input angle_raw, input accel_x,
    input accel_y, input accel_z, input turns, input unwrapped_angle,
    output ready
  );
endinterface

// ===== rtl/core/gyro_frame_parser_angle_unwrap.sv =====
// Gyro frame parser: header hunt, checksum, value latch and angle unwrap.
// Depends on gfp_pkg, gfp_ifs.sv and assert_macros.svh.
//
//   channel  dir  handshake        payload
//   rx       in   valid/ready      rx_byte
//   res      out  valid/ready      checksum_ok, angle_raw, accel_x/y/z,
//                                  turns, unwrapped_angle
//   apb      in   psel/penable     wrap_threshold, turn_span
//
// One byte is taken per cycle while rx is not stalled. After a frame's
// last byte, the held values and turn count are updated first; then the
// turn*span multiply is saturated into the output register.
// Reset is synchronous and clears parser, held values and turn count.
// A stalled output holds the pending result stage, which then holds rx.
`include "assert_macros.svh"

module gyro_frame_parser_angle_unwrap (
  input  logic                         clk,
  input  logic                         rst,
  gfp_in_if.sink                       rx,
  gfp_out_if.source                    res,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gfp_pkg::PADDR_W-1:0]  paddr,
  input  logic [gfp_pkg::PDATA_W-1:0]  pwdata,
  output logic [gfp_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import gfp_pkg::*;

  logic [VALUE_W-1:0] wrap_threshold;
  logic [VALUE_W-1:0] turn_span;

  hunt_t             state, state_next;
  logic [IDX_W-1:0]  payload_index, payload_index_next;
  logic [BYTE_W-1:0] running_sum, running_sum_next;
  logic [BYTE_W-1:0] payload_store [FRAME_LEN];

  value_t held_angle;
  value_t held_accel_x;
  value_t held_accel_y;
  value_t held_accel_z;
  value_t turn_count;

  logic s1_valid;
  logic s1_ok;

  logic accept;
  logic cfg_write;
  logic last_beat;
  logic frame_ok;
  logic s1_move;

  value_t                    new_angle;
  logic signed [VALUE_W:0]   angle_diff;
  logic signed [VALUE_W:0]   thr;
  logic                      wrap_down;
  logic                      wrap_up;
  logic signed [2*VALUE_W:0] product;
  logic signed [UNW_W+1:0]   unw_sum;
  logic signed [UNW_W+1:0]   unw_neg;
  logic [UNW_W-1:0]          unw_sat;

  // Configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[2])
      REG_WRAP_THRESHOLD: prdata = {{(PDATA_W-VALUE_W){1'b0}}, wrap_threshold};
      REG_TURN_SPAN:      prdata = {{(PDATA_W-VALUE_W){1'b0}}, turn_span};
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_threshold <= WRAP_THRESHOLD_RST;
      turn_span      <= TURN_SPAN_RST;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_WRAP_THRESHOLD: wrap_threshold <= pwdata[VALUE_W-1:0];
        REG_TURN_SPAN:      turn_span      <= pwdata[VALUE_W-1:0];
        default: ;
      endcase
    end
  end

  // Input handshake: stall only when both result stages are full and held.
  assign s1_move  = s1_valid && (!res.valid || res.ready);
  assign rx.ready = !s1_valid || !res.valid || res.ready;
  assign accept   = rx.valid && rx.ready;

  assign last_beat = (state == ST_LOAD) && (payload_index == LAST_IDX);
  assign frame_ok  = last_beat && (running_sum == rx.rx_byte);

  // Header hunt and payload collection
  always_comb begin
    state_next         = state;
    payload_index_next = payload_index;
    running_sum_next   = running_sum;
    case (state)
      ST_ZERO: begin
        state_next         = (rx.rx_byte == HDR_SECOND) ? ST_LOAD : ST_SYNC;
        payload_index_next = '0;
      end
      ST_LOAD: begin
        payload_index_next = payload_index + IDX_W'(1);
        if (payload_index < SUM_LIMIT) begin
          running_sum_next = running_sum + rx.rx_byte;
        end
        if (last_beat) begin
          state_next         = ST_SYNC;
          payload_index_next = '0;
          running_sum_next   = '0;
        end
      end
      default: begin
        state_next = (rx.rx_byte == HDR_FIRST) ? ST_ZERO : ST_SYNC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_SYNC;
      payload_index <= '0;
      running_sum   <= '0;
    end else if (accept) begin
      state         <= state_next;
      payload_index <= payload_index_next;
      running_sum   <= running_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && state == ST_LOAD) begin
      payload_store[payload_index] <= rx.rx_byte;
    end
  end

  // Wrap detection against the angle held before this frame
  assign new_angle  = {payload_store[2], payload_store[1]};
  assign angle_diff = {new_angle[VALUE_W-1], new_angle}
                    - {held_angle[VALUE_W-1], held_angle};
  assign thr        = $signed({1'b0, wrap_threshold});
  assign wrap_down  = angle_diff > thr;
  assign wrap_up    = angle_diff < -thr;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_angle   <= '0;
      held_accel_x <= '0;
      held_accel_y <= '0;
      held_accel_z <= '0;
      turn_count   <= '0;
    end else if (accept && frame_ok) begin
      held_angle   <= new_angle;
      held_accel_x <= {payload_store[6], payload_store[5]};
      held_accel_y <= {payload_store[8], payload_store[7]};
      held_accel_z <= {payload_store[10], payload_store[9]};
      if (wrap_down) begin
        if (turn_count != TURN_MIN) turn_count <= turn_count - VALUE_W'(1);
      end else if (wrap_up) begin
        if (turn_count != TURN_MAX) turn_count <= turn_count + VALUE_W'(1);
      end
    end
  end

  // Pending result: the held values stay put until it moves on.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      if (s1_move) s1_valid <= 1'b0;
      if (accept && last_beat) s1_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last_beat) begin
      s1_ok <= frame_ok;
    end
  end

  // Unwrap: negate turns*span + angle, saturate to 32 bits
  assign product = (2*VALUE_W+1)'(turn_count) * (2*VALUE_W+1)'($signed({1'b0, turn_span}));
  assign unw_sum = {product[2*VALUE_W], product}
                 + {{(UNW_W+2-VALUE_W){held_angle[VALUE_W-1]}}, held_angle};
  assign unw_neg = -unw_sum;
  always_comb begin
    if (unw_neg[UNW_W+1:UNW_W-1] == 3'b000 || unw_neg[UNW_W+1:UNW_W-1] == 3'b111) begin
      unw_sat = unw_neg[UNW_W-1:0];
    end else if (unw_neg[UNW_W+1]) begin
      unw_sat = UNW_MIN;
    end else begin
      unw_sat = UNW_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (s1_move) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      res.checksum_ok     <= s1_ok;
      res.angle_raw       <= held_angle;
      res.accel_x         <= held_accel_x;
      res.accel_y         <= held_accel_y;
      res.accel_z         <= held_accel_z;
      res.turns           <= turn_count;
      res.unwrapped_angle <= unw_sat;
    end
  end

  `ASSERT_IMPLIES(a_pend_in_sync, s1_valid, state == ST_SYNC,
    "pending result while parser is not hunting")
  `ASSERT_IMPLIES(a_stall_cause, !rx.ready, s1_valid && res.valid && !res.ready,
    "rx stalled without a full, held result path")
  `ASSERT_IMPLIES(a_idle_counters, state != ST_LOAD,
    payload_index == '0 && running_sum == '0,
    "payload counters not cleared outside payload")
  `ASSERT_NEXT(a_turn_hold, !(accept && frame_ok), $stable(turn_count),
    "turn count moved without a good frame")
  `ASSERT_IMPLIES(a_index_range, 1'b1, payload_index <= LAST_IDX,
    "payload index past frame end")

endmodule

// ===== dv/gyro_frame_parser_angle_unwrap_tb.sv =====
// Testbench for gyro_frame_parser_angle_unwrap: byte stream in, frame results out.
// Needs gfp_pkg, gfp_in_if / gfp_out_if and the top level; predicts each frame
// in-house and scores every result beat against it.
`timescale 1ns / 100ps

module gyro_frame_parser_angle_unwrap_tb;
  import gfp_pkg::*;

  localparam int CLK_HALF    = 4;
  localparam int RST_CYCLES  = 6;
  localparam int SETTLE      = 8;
  localparam int LONG_HOLD   = 300;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 200;

  localparam longint UNW_HI = 64'sd2147483647;
  localparam longint UNW_LO = -64'sd2147483648;

  typedef enum logic [1:0] {
    SEEK_AA,
    SEEK_ZERO,
    COLLECT
  } parse_phase_t;

  typedef struct packed {
    logic                    ok;
    value_t                  angle;
    value_t                  accel_x;
    value_t                  accel_y;
    value_t                  accel_z;
    value_t                  turns;
    logic signed [UNW_W-1:0] unw;
  } frame_res_t;

  localparam frame_res_t NO_RES = '0;

  // Directed bytes: repeated 0xAA header, a good frame with extreme values,
  // then the same frame with a broken checksum.
  localparam int DIR_ROWS = 32;
  localparam int GOOD_ROW = 16;
  localparam int BAD_ROW  = 31;
  localparam logic [7:0] DIR_BYTES [DIR_ROWS] = '{
    8'hAA, 8'hAA, 8'hAA, 8'h00,
    8'h00, 8'h00, 8'h80, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h00, 8'h80, 8'hFF, 8'hFF,
    8'h55, 8'h7A,
    8'hAA, 8'h00,
    8'h00, 8'h00, 8'h80, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h00, 8'h80, 8'hFF, 8'hFF,
    8'h55, 8'h7B
  };
  localparam frame_res_t GOOD_EXP = '{ok: 1'b1, angle: 16'sh8000, accel_x: 16'sh7FFF,
                                      accel_y: 16'sh8000, accel_z: 16'shFFFF,
                                      turns: 16'sd1, unw: -32'sd3232};
  localparam frame_res_t BAD_EXP  = '{ok: 1'b0, angle: 16'sh8000, accel_x: 16'sh7FFF,
                                      accel_y: 16'sh8000, accel_z: 16'shFFFF,
                                      turns: 16'sd1, unw: -32'sd3232};

  localparam logic [15:0] PH_THR  [PHASES] = '{16'd18000, 16'd0, 16'd65535, 16'd0,
                                              16'd100, 16'd0};
  localparam logic [15:0] PH_SPAN [PHASES] = '{16'd36000, 16'd0, 16'd65535, 16'd0,
                                              16'd65535, 16'd0};
  localparam bit PH_RAND [PHASES] = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                psel, penable, pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  gfp_in_if  byte_ch ();
  gfp_out_if frame_ch ();

  gyro_frame_parser_angle_unwrap uut (
    .clk     (clk),
    .rst     (rst),
    .rx      (byte_ch),
    .res     (frame_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #CLK_HALF clk = ~clk;

  // Frame predictor state.
  parse_phase_t parse_phase = SEEK_AA;
  int           slot = 0;
  logic [7:0]   frame_buf [FRAME_LEN];
  logic [7:0]   sum_acc = '0;
  value_t       held_ang = '0;
  value_t       prev_ang = '0;
  value_t       held_acc [3] = '{'0, '0, '0};
  value_t       turn_q = '0;
  logic [15:0]  thr_q = WRAP_THRESHOLD_RST;
  logic [15:0]  span_q = TURN_SPAN_RST;

  frame_res_t pending_frames [$];
  int  mismatches = 0;
  int  bytes_sent = 0;
  int  cycles = 0;
  bit  calm = 1'b0;
  int  long_hold_asked = 0;
  int  long_hold_served = 0;
  int  hold_left = 0;

  task automatic parse_byte(input logic [7:0] b, output bit done, output frame_res_t r);
    bit     ok;
    int     diff;
    int     lim;
    longint unw;
    done = 1'b0;
    ok   = 1'b0;
    case (parse_phase)
      SEEK_ZERO: begin
        if (b == HDR_SECOND) begin
          parse_phase = COLLECT;
        end else begin
          parse_phase = SEEK_AA;
          slot = 0;
        end
      end
      COLLECT: begin
        if (slot >= FRAME_LEN) slot = 0;
        frame_buf[slot] = b;
        if (slot < SUM_LEN) sum_acc = sum_acc + b;
        slot++;
        if (slot >= FRAME_LEN) begin
          done = 1'b1;
          if (sum_acc == frame_buf[FRAME_LEN-1]) begin
            ok = 1'b1;
            held_ang    = {frame_buf[2], frame_buf[1]};
            held_acc[0] = {frame_buf[6], frame_buf[5]};
            held_acc[1] = {frame_buf[8], frame_buf[7]};
            held_acc[2] = {frame_buf[10], frame_buf[9]};
          end
          parse_phase = SEEK_AA;
          slot = 0;
          sum_acc = '0;
        end
      end
      default: parse_phase = (b == HDR_FIRST) ? SEEK_ZERO : SEEK_AA;
    endcase

    // Unwrap: a big positive jump loses a turn, a big negative one gains one.
    diff = int'(held_ang) - int'(prev_ang);
    lim  = int'(thr_q);
    if (diff > lim) begin
      if (turn_q != TURN_MIN) turn_q = turn_q - 16'sd1;
    end else if (diff < -lim) begin
      if (turn_q != TURN_MAX) turn_q = turn_q + 16'sd1;
    end
    prev_ang = held_ang;

    unw = -(longint'(turn_q) * longint'(span_q) + longint'(held_ang));
    if (unw > UNW_HI) unw = UNW_HI;
    if (unw < UNW_LO) unw = UNW_LO;
    r.ok      = ok;
    r.angle   = held_ang;
    r.accel_x = held_acc[0];
    r.accel_y = held_acc[1];
    r.accel_z = held_acc[2];
    r.turns   = turn_q;
    r.unw     = unw[UNW_W-1:0];
  endtask

  task automatic send_byte(input logic [7:0] b, input bit typed, input frame_res_t typed_res);
    bit         done;
    frame_res_t r;
    int         gap;
    int         roll;
    byte_ch.valid   <= 1'b1;
    byte_ch.rx_byte <= b;
    do @(posedge clk); while (!byte_ch.ready);
    parse_byte(b, done, r);
    if (typed) pending_frames.push_back(typed_res);
    else if (done) pending_frames.push_back(r);
    bytes_sent++;
    roll = $urandom_range(0, 99);
    if (calm || roll < 55) gap = 0;
    else if (roll < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(5, 40);
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Header plus 13 payload bytes; the angle is steered around the wrap limit.
  task automatic send_frame(input bit good);
    logic [7:0] pl [FRAME_LEN];
    logic [7:0] sum;
    int         a;
    int         lim;
    lim = int'(thr_q);
    case ($urandom_range(0, 5))
      0: a = int'($urandom_range(0, 65535));
      1: a = int'(held_ang) + int'($urandom_range(0, 200)) - 100;
      2: a = int'(held_ang) + lim + 1;
      3: a = int'(held_ang) - lim - 1;
      4: a = int'(held_ang) + lim;
      default: a = int'(held_ang) - lim;
    endcase
    for (int k = 0; k < FRAME_LEN; k++) pl[k] = 8'($urandom_range(0, 255));
    pl[1] = a[7:0];
    pl[2] = a[15:8];
    sum = '0;
    for (int k = 0; k < SUM_LEN; k++) sum = sum + pl[k];
    pl[FRAME_LEN-1] = good ? sum : sum + 8'($urandom_range(1, 255));
    send_byte(HDR_FIRST, 1'b0, NO_RES);
    send_byte(HDR_SECOND, 1'b0, NO_RES);
    for (int k = 0; k < FRAME_LEN; k++) send_byte(pl[k], 1'b0, NO_RES);
  endtask

  task automatic write_reg(input logic reg_sel, input logic [15:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= {16'b0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_sel == REG_WRAP_THRESHOLD) thr_q = val;
    else span_q = val;
    @(posedge clk);
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : frame_check
    frame_res_t want;
    if (!rst && frame_ch.valid && frame_ch.ready) begin
      if (pending_frames.size() == 0) begin
        $display("%0t: result beat with nothing expected, angle_raw %0d", $time,
                 frame_ch.angle_raw);
        mismatches++;
      end else begin
        want = pending_frames.pop_front();
        check_field("checksum_ok", want.ok, frame_ch.checksum_ok);
        check_field("angle_raw", value_t'(want.angle), frame_ch.angle_raw);
        check_field("accel_x", value_t'(want.accel_x), frame_ch.accel_x);
        check_field("accel_y", value_t'(want.accel_y), frame_ch.accel_y);
        check_field("accel_z", value_t'(want.accel_z), frame_ch.accel_z);
        check_field("turns", value_t'(want.turns), frame_ch.turns);
        check_field("unwrapped_angle", $signed(want.unw), frame_ch.unwrapped_angle);
      end
    end
  end

  // Result sink: random stalls, plus one long hold-off on request.
  always @(posedge clk) begin : sink_drive
    int roll;
    roll = $urandom_range(0, 99);
    if (rst) begin
      frame_ch.ready <= 1'b1;
    end else if (hold_left > 0) begin
      frame_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (long_hold_asked != long_hold_served) begin
      frame_ch.ready   <= 1'b0;
      hold_left        <= LONG_HOLD;
      long_hold_served <= long_hold_asked;
    end else if (calm || roll < 70) begin
      frame_ch.ready <= 1'b1;
    end else if (roll < 95) begin
      frame_ch.ready <= 1'b0;
      hold_left <= $urandom_range(0, 3);
    end else begin
      frame_ch.ready <= 1'b0;
      hold_left <= $urandom_range(10, 40);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : main_seq
    int          roll;
    logic [15:0] thr_v;
    logic [15:0] span_v;
    byte_ch.valid   = 1'b0;
    byte_ch.rx_byte = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_byte(DIR_BYTES[i], (i == GOOD_ROW) || (i == BAD_ROW),
                (i == GOOD_ROW) ? GOOD_EXP : BAD_EXP);
    end

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        thr_v  = PH_RAND[p] ? 16'($urandom_range(0, 40000)) : PH_THR[p];
        span_v = PH_RAND[p] ? 16'($urandom_range(0, 65535)) : PH_SPAN[p];
        write_reg(REG_WRAP_THRESHOLD, thr_v);
        write_reg(REG_TURN_SPAN, span_v);
      end
      calm = (p == 1);
      // Block the sink so the parser backs up into the byte channel.
      if (p == 2) long_hold_asked++;
      while (bytes_sent < DIR_ROWS + (p + 1) * PHASE_ITEMS) begin
        roll = $urandom_range(0, 99);
        if (roll < 72) begin
          send_frame(1'b1);
        end else if (roll < 84) begin
          send_frame(1'b0);
        end else if (roll < 92) begin
          send_byte(HDR_FIRST, 1'b0, NO_RES);
          send_byte(8'($urandom_range(1, 255)), 1'b0, NO_RES);
        end else begin
          repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)), 1'b0, NO_RES);
        end
      end
      // Drain every pending result and let the pipeline settle.
      byte_ch.valid <= 1'b0;
      while (pending_frames.size() != 0) @(posedge clk);
      repeat (SETTLE) @(posedge clk);
    end

    if (mismatches == 0 && pending_frames.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/gfp_pkg.sv
rtl/core/gfp_ifs.sv
rtl/core/gyro_frame_parser_angle_unwrap.sv
dv/gyro_frame_parser_angle_unwrap_tb.sv
